@@ hdl/sha3r_pkg.sv @@
// Package: SHA-256 round constants, word types and round functions for the precompute chain.
package sha3r_pkg;

	localparam int ROUNDS = 3;
	localparam int STAGES_PER_ROUND = 2;
	localparam int DEPTH = ROUNDS * STAGES_PER_ROUND;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef logic [31:0] word_t;

	localparam word_t ROUND_K [ROUNDS] = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf};

	typedef struct packed {
		word_t               a;
		word_t               b;
		word_t               c;
		word_t               d;
		word_t               e;
		word_t               f;
		word_t               g;
		word_t               h;
		word_t [ROUNDS-1:0]  msg;
		word_t [ROUNDS-1:0]  res_a;
		word_t [ROUNDS-1:0]  res_e;
	} work_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t choose(input word_t e, input word_t f, input word_t g);
		choose = g ^ (e & (f ^ g));
	endfunction

	function automatic word_t majority(input word_t a, input word_t b, input word_t c);
		majority = (a & b) | (c & (a | b));
	endfunction

endpackage

@@ hdl/sha3r_round_cell.sv @@
// One SHA-256 round as a two-stage cell of the precompute chain.
module sha3r_round_cell
	import sha3r_pkg::*;
#(
	parameter int ROUND = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  work_t in_work,
	output logic  out_valid,
	input  logic  out_stall,
	output work_t out_work
);

	logic  vld_s1, vld_s2;
	logic  stall_s1;
	work_t work_s1, work_s2;
	word_t t1_s1, t2_s1;
	word_t t1_d, t2_d;
	word_t new_a, new_e;
	work_t next_work;

	// Stage 1: form T1 and T2 from the incoming working values.
	always_comb begin
		t1_d = in_work.h + big_sigma1(in_work.e) + choose(in_work.e, in_work.f, in_work.g)
			+ ROUND_K[ROUND] + in_work.msg[ROUND];
		t2_d = big_sigma0(in_work.a) + majority(in_work.a, in_work.b, in_work.c);
	end

	assign stall_s1 = vld_s1 && vld_s2 && out_stall;
	assign in_stall = stall_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!stall_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s1 && in_valid) begin
			work_s1 <= in_work;
			t1_s1   <= t1_d;
			t2_s1   <= t2_d;
		end
	end

	// Stage 2: finish the round, shift the working values and record the results.
	always_comb begin
		new_a = t1_s1 + t2_s1;
		new_e = work_s1.d + t1_s1;
		next_work = work_s1;
		next_work.h = work_s1.g;
		next_work.g = work_s1.f;
		next_work.f = work_s1.e;
		next_work.e = new_e;
		next_work.d = work_s1.c;
		next_work.c = work_s1.b;
		next_work.b = work_s1.a;
		next_work.a = new_a;
		next_work.res_a[ROUND] = new_a;
		next_work.res_e[ROUND] = new_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!(vld_s2 && out_stall)) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!(vld_s2 && out_stall) && vld_s1) begin
			work_s2 <= next_work;
		end
	end

	assign out_valid = vld_s2;
	assign out_work  = work_s2;

endmodule

@@ hdl/sha256_three_round_precompute.sv @@
// Top level: three chained SHA-256 round cells that precompute a and e from a midstate.
// Each round adds two register stages between input transfer and output valid.
// Throughput: one item per cycle unless stalled; each cell holds up to two items in flight.
// Stall propagates back through the cells; input stalls only when all six stages are full
// and the output is stalled.
// Reset: arst_n asynchronously clears all stage valid bits; payload registers are not reset.
module sha256_three_round_precompute
	import sha3r_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,

	input  logic  in_valid,
	output logic  in_stall,
	input  word_t mid_a,
	input  word_t mid_b,
	input  word_t mid_c,
	input  word_t mid_d,
	input  word_t mid_e,
	input  word_t mid_f,
	input  word_t mid_g,
	input  word_t mid_h,
	input  word_t msg_word0,
	input  word_t msg_word1,
	input  word_t msg_word2,

	output logic  out_valid,
	input  logic  out_stall,
	output word_t a_round0,
	output word_t a_round1,
	output word_t a_round2,
	output word_t e_round0,
	output word_t e_round1,
	output word_t e_round2
);

	// Link signals between cells: index 0 is the input side, index ROUNDS the output side.
	logic  link_valid [ROUNDS+1];
	logic  link_stall [ROUNDS+1];
	work_t link_work  [ROUNDS+1];
	work_t in_work;

	logic [CNT_W-1:0] inflight_q;
	logic             in_xfer, out_xfer;

	// Pack the input transfer into the work record; result slots fill as rounds complete.
	always_comb begin
		in_work        = '0;
		in_work.a      = mid_a;
		in_work.b      = mid_b;
		in_work.c      = mid_c;
		in_work.d      = mid_d;
		in_work.e      = mid_e;
		in_work.f      = mid_f;
		in_work.g      = mid_g;
		in_work.h      = mid_h;
		in_work.msg[0] = msg_word0;
		in_work.msg[1] = msg_word1;
		in_work.msg[2] = msg_word2;
	end

	assign link_work[0]       = in_work;
	assign link_valid[0]      = in_valid;
	assign in_stall           = link_stall[0];
	assign link_stall[ROUNDS] = out_stall;

	// Chain one cell per round; each hands its work record to the next unless stalled.
	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		sha3r_round_cell #(
			.ROUND(r)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (link_valid[r]),
			.in_stall (link_stall[r]),
			.in_work  (link_work[r]),
			.out_valid(link_valid[r+1]),
			.out_stall(link_stall[r+1]),
			.out_work (link_work[r+1])
		);
	end

	assign out_valid = link_valid[ROUNDS];
	assign a_round0  = link_work[ROUNDS].res_a[0];
	assign a_round1  = link_work[ROUNDS].res_a[1];
	assign a_round2  = link_work[ROUNDS].res_a[2];
	assign e_round0  = link_work[ROUNDS].res_e[0];
	assign e_round1  = link_work[ROUNDS].res_e[1];
	assign e_round2  = link_work[ROUNDS].res_e[2];

	// Track items held in the chain for the checks below.
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			inflight_q <= inflight_q + CNT_W'(1);
		end else if (out_xfer && !in_xfer) begin
			inflight_q <= inflight_q - CNT_W'(1);
		end
	end

	// Never hold more items than there are stages.
	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(DEPTH))
		else $error("more items in flight than pipeline stages");

	// An empty chain shows no result.
	a_empty_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(inflight_q == '0) |-> !out_valid)
		else $error("output valid with no item in flight");

	// Stall the input only when every stage is full and the output is held.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_stall && (inflight_q == CNT_W'(DEPTH))))
		else $error("input stalled while the chain has room");

endmodule
